### sv/dsf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dsf_pkg;

   // Sample format: signed Q1.(SAMPLE_WIDTH-1)
   localparam int SAMPLE_WIDTH = 16;
   localparam int NUM_LANES    = 3;
   localparam int DZ_WIDTH     = 15;
   localparam int WEIGHT_WIDTH = 17;
   localparam int CSR_IDX_WIDTH = 2;

   // Dead zone alignment to sample scale
   localparam int DZ_SHL = (SAMPLE_WIDTH >= 16) ? SAMPLE_WIDTH - 16 : 0;
   localparam int DZ_SHR = (SAMPLE_WIDTH < 16) ? 16 - SAMPLE_WIDTH : 0;

   localparam logic [WEIGHT_WIDTH-1:0] W_ONE = WEIGHT_WIDTH'(65536);
   localparam logic [SAMPLE_WIDTH-1:0] ONE   = SAMPLE_WIDTH'(1) << (SAMPLE_WIDTH - 1);

   // Register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_STEERING_DZ = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_THROTTLE_DZ = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_BRAKE_DZ    = 2'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_WEIGHT      = 2'd3;

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;

   typedef struct packed {
      sample_type steering_in;
      sample_type throttle_in;
      sample_type brake_in;
   } req_payload_type;

   typedef struct packed {
      sample_type steering_out;
      sample_type throttle_out;
      sample_type brake_out;
   } rsp_payload_type;

   // Top to lane control
   typedef struct packed {
      logic start;
      logic take;
   } lane_ctrl_type;

   // Lane to top status
   typedef struct packed {
      logic idle;
      logic done;
   } lane_stat_type;

   typedef enum logic [2:0] {
      LANE_IDLE,
      LANE_DIV,
      LANE_MUL,
      LANE_SUM,
      LANE_DONE
   } lane_state_type;

   // Bring a 15-bit Q0.15 dead zone to sample scale
   function automatic logic [SAMPLE_WIDTH-1:0] scale_dz(input logic [DZ_WIDTH-1:0] dz);
      logic [SAMPLE_WIDTH+DZ_WIDTH-1:0] wide;
      wide = (SAMPLE_WIDTH+DZ_WIDTH)'(dz);
      wide = (wide << DZ_SHL) >> DZ_SHR;
      return wide[SAMPLE_WIDTH-1:0];
   endfunction

endpackage

`default_nettype wire

### sv/deadzone_smoothing_filter_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Dead-zone and smoothing filter for steering, throttle and brake (signed
// Q1.15). Each channel runs in its own lane: the magnitude minus the dead
// zone is rescaled by a bit-serial divider (one quotient bit per cycle),
// then blended with the channel's last output using the shared Q1.16 weight
// (rounded, saturated). Each request passes the per-lane divider, then the
// multiply and sum steps, to its result. The lanes can take the next
// request in the cycle after they hand off a result. One request is in the
// lanes at a time, and the next is taken while a result waits on rsp_; a
// second finished result holds the lanes, and so the input, until the first
// is taken. Weights above 65536 act as 65536. Write the CSRs only while
// idle.
module deadzone_smoothing_filter_top (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_valid,
   output logic                                         req_ready,
   input  wire dsf_pkg::req_payload_type                req_payload,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_ready,
   output dsf_pkg::rsp_payload_type                     rsp_payload,
   input  wire logic                                    csr_valid,
   output logic                                         csr_ready,
   input  wire logic [dsf_pkg::CSR_IDX_WIDTH-1:0]       csr_index,
   input  wire logic [dsf_pkg::WEIGHT_WIDTH-1:0]        csr_wdata
);

   localparam int NL = dsf_pkg::NUM_LANES;
   localparam int DW = dsf_pkg::DZ_WIDTH;
   localparam int WW = dsf_pkg::WEIGHT_WIDTH;

   logic [DW-1:0] dz_steer_ff, dz_throt_ff, dz_brake_ff;
   logic [WW-1:0] weight_ff;
   logic [WW-1:0] weight_eff;

   logic                     rsp_valid_ff, rsp_valid_in;
   dsf_pkg::rsp_payload_type rsp_data_ff;

   dsf_pkg::lane_ctrl_type   ctrl;
   dsf_pkg::lane_stat_type   stat [NL];
   dsf_pkg::sample_type      res  [NL];

   logic all_idle, all_done, merge;

   // Config registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dz_steer_ff <= '0;
         dz_throt_ff <= '0;
         dz_brake_ff <= '0;
         weight_ff   <= dsf_pkg::W_ONE;
      end else if (csr_valid) begin
         case (csr_index)
            dsf_pkg::CSR_STEERING_DZ: dz_steer_ff <= csr_wdata[DW-1:0];
            dsf_pkg::CSR_THROTTLE_DZ: dz_throt_ff <= csr_wdata[DW-1:0];
            dsf_pkg::CSR_BRAKE_DZ:    dz_brake_ff <= csr_wdata[DW-1:0];
            dsf_pkg::CSR_WEIGHT:      weight_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Clamp weight to one
   assign weight_eff = weight_ff[WW-1] ? dsf_pkg::W_ONE : weight_ff;

   // Lane control
   always_comb begin
      all_idle   = stat[0].idle & stat[1].idle & stat[2].idle;
      all_done   = stat[0].done & stat[1].done & stat[2].done;
      merge      = all_done && (!rsp_valid_ff || rsp_ready);
      ctrl.start = req_valid && all_idle;
      ctrl.take  = merge;
   end

   assign req_ready = all_idle;

   dsf_lane u_lane_steer (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .x      (req_payload.steering_in),
      .dz     (dz_steer_ff),
      .weight (weight_eff),
      .stat   (stat[0]),
      .result (res[0])
   );

   dsf_lane u_lane_throt (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .x      (req_payload.throttle_in),
      .dz     (dz_throt_ff),
      .weight (weight_eff),
      .stat   (stat[1]),
      .result (res[1])
   );

   dsf_lane u_lane_brake (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .x      (req_payload.brake_in),
      .dz     (dz_brake_ff),
      .weight (weight_eff),
      .stat   (stat[2]),
      .result (res[2])
   );

   // Merge lane results into the output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (merge)
         rsp_valid_in = 1'b1;
      else if (rsp_ready)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else
         rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (merge) begin
         rsp_data_ff.steering_out <= res[0];
         rsp_data_ff.throttle_out <= res[1];
         rsp_data_ff.brake_out    <= res[2];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

`default_nettype wire

### sv/dsf_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle.
// Requires dividend <= divisor; quotient = dividend * ONE / divisor.
module dsf_div (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   input  wire logic [dsf_pkg::SAMPLE_WIDTH-1:0]   dividend,
   input  wire logic [dsf_pkg::SAMPLE_WIDTH-1:0]   divisor,
   output logic                                    done,
   output logic [dsf_pkg::SAMPLE_WIDTH-1:0]        quotient
);

   localparam int SW = dsf_pkg::SAMPLE_WIDTH;
   localparam int CW = $clog2(SW + 1);

   logic [SW:0]   rem_ff, rem_in;
   logic [SW-1:0] quo_ff, quo_in;
   logic [SW-1:0] dvs_ff, dvs_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          done_ff, done_in;

   logic          ge;
   logic [SW:0]   diff;

   // One compare/subtract step
   always_comb begin
      ge   = rem_ff >= {1'b0, dvs_ff};
      diff = ge ? rem_ff - {1'b0, dvs_ff} : rem_ff;
   end

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = {1'b0, dividend};
         dvs_in = divisor;
         quo_in = '0;
         cnt_in = CW'(SW);
      end else if (cnt_ff != '0) begin
         // remainder stays below divisor, so it fits SW bits before doubling
         rem_in  = {diff[SW-1:0], 1'b0};
         quo_in  = {quo_ff[SW-2:0], ge};
         cnt_in  = cnt_ff - CW'(1);
         done_in = (cnt_ff == CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

### sv/dsf_lane.sv
`timescale 1ns / 1ps
`default_nettype none

// One channel: scaled dead zone, then exponential moving average against the kept value.
module dsf_lane (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire dsf_pkg::lane_ctrl_type                ctrl,
   input  wire dsf_pkg::sample_type                   x,
   input  wire logic [dsf_pkg::DZ_WIDTH-1:0]          dz,
   input  wire logic [dsf_pkg::WEIGHT_WIDTH-1:0]      weight,
   output dsf_pkg::lane_stat_type                     stat,
   output dsf_pkg::sample_type                        result
);

   localparam int SW   = dsf_pkg::SAMPLE_WIDTH;
   localparam int WW   = dsf_pkg::WEIGHT_WIDTH;
   localparam int PW   = SW + WW + 1;
   localparam int SUMW = PW + 2;
   localparam int SHW  = SUMW - 16;

   localparam logic signed [SHW-1:0] SAT_HI = SHW'((64'sd1 <<< (SW - 1)) - 64'sd1);
   localparam logic signed [SHW-1:0] SAT_LO = SHW'(-(64'sd1 <<< (SW - 1)));
   localparam logic signed [SUMW-1:0] RND   = SUMW'(32768);

   dsf_pkg::lane_state_type state_ff, state_in;

   logic                       neg_ff;
   logic                       zero_ff;
   dsf_pkg::sample_type        y_ff;
   dsf_pkg::sample_type        prev_ff, prev_in;
   logic signed [PW-1:0]       prod_a_ff, prod_b_ff;

   logic [SW-1:0]  dz_s;
   logic [SW-1:0]  mag;
   logic [SW-1:0]  numer;
   logic [SW-1:0]  denom;
   logic           div_start;
   logic           div_done;
   logic [SW-1:0]  quo;
   logic [SW-1:0]  quo_neg;
   logic [WW-1:0]  inv_w;
   logic signed [SUMW-1:0] sum;
   logic signed [SHW-1:0]  shifted;

   // Dead-zone front end from the accepted sample
   always_comb begin
      dz_s  = dsf_pkg::scale_dz(dz);
      mag   = x[SW-1] ? (~x + SW'(1)) : x;
      numer = (mag >= dz_s) ? mag - dz_s : '0;
      denom = dsf_pkg::ONE - dz_s;
   end

   dsf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (numer),
      .divisor  (denom),
      .done     (div_done),
      .quotient (quo)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dsf_pkg::LANE_IDLE: if (ctrl.start) state_in = dsf_pkg::LANE_DIV;
         dsf_pkg::LANE_DIV:  if (div_done)   state_in = dsf_pkg::LANE_MUL;
         dsf_pkg::LANE_MUL:  state_in = dsf_pkg::LANE_SUM;
         dsf_pkg::LANE_SUM:  state_in = dsf_pkg::LANE_DONE;
         dsf_pkg::LANE_DONE: if (ctrl.take)  state_in = dsf_pkg::LANE_IDLE;
         default:            state_in = dsf_pkg::LANE_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      div_start = 1'b0;
      stat.idle = 1'b0;
      stat.done = 1'b0;
      case (state_ff)
         dsf_pkg::LANE_IDLE: begin
            stat.idle = 1'b1;
            div_start = ctrl.start;
         end
         dsf_pkg::LANE_DONE: stat.done = 1'b1;
         default: ;
      endcase
   end

   // Smoothing arithmetic
   always_comb begin
      quo_neg = ~quo + SW'(1);
      inv_w   = dsf_pkg::W_ONE - weight;
      sum     = SUMW'(prod_a_ff) + SUMW'(prod_b_ff) + RND;
      shifted = SHW'(sum >>> 16);
      if (shifted > SAT_HI)
         prev_in = SW'(SAT_HI);
      else if (shifted < SAT_LO)
         prev_in = SW'(SAT_LO);
      else
         prev_in = SW'(shifted);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dsf_pkg::LANE_IDLE;
         prev_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == dsf_pkg::LANE_SUM)
            prev_ff <= prev_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (state_ff == dsf_pkg::LANE_IDLE && ctrl.start) begin
         neg_ff  <= x[SW-1];
         zero_ff <= (x == '0);
      end
      if (state_ff == dsf_pkg::LANE_DIV && div_done)
         y_ff <= (neg_ff || zero_ff) ? quo_neg : quo;
      if (state_ff == dsf_pkg::LANE_MUL) begin
         prod_a_ff <= PW'(prev_ff) * PW'($signed({1'b0, inv_w}));
         prod_b_ff <= PW'(y_ff) * PW'($signed({1'b0, weight}));
      end
   end

   assign result = prev_ff;

endmodule

`default_nettype wire
